@@ src/htt_pkg.sv @@
package htt_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_DEL_IP = 3'd1;
	localparam logic [2:0] MODE_SWEEP  = 3'd2;
	localparam logic [2:0] MODE_PURGE  = 3'd3;
	localparam logic [2:0] MODE_M_IP   = 3'd4;
	localparam logic [2:0] MODE_M_MAC  = 3'd5;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [16:0] TIMEOUT_RST = 17'd60;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_APPLY,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic apply;
	} cmd_t;

endpackage

@@ src/htt_datapath.sv @@
module htt_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  htt_pkg::cmd_t               cmd,
	input  logic [16:0]                 timeout_sec,
	input  logic [2:0]                  mode,
	input  logic [31:0]                 now_sec,
	input  logic [31:0]                 ip_a,
	input  logic [31:0]                 ip_b,
	input  logic [47:0]                 mac_a,
	input  logic [47:0]                 mac_b,
	input  logic [15:0]                 tag_id,
	input  logic                        has_ip,
	input  logic                        has_mac,
	input  logic                        no_expiry,
	output logic                        matched,
	output logic [15:0]                 tag_out,
	output logic [8:0]                  active_count,
	output logic [1:0]                  status
);

	localparam int N = htt_pkg::TABLE_ENTRIES;
	localparam int IW = htt_pkg::IDX_W;
	localparam int CW = htt_pkg::CNT_W;

	logic [N-1:0]  vld_q;
	logic [31:0]   ip_q    [N];
	logic          hip_q   [N];
	logic [47:0]   mac_q   [N];
	logic [15:0]   tag_q   [N];
	logic [31:0]   exp_q   [N];
	logic [IW-1:0] rank_q  [N];
	logic [CW-1:0] cnt_q;

	logic [2:0]  mode_q;
	logic [31:0] now_q, ipa_q, ipb_q, newexp_q;
	logic [47:0] maca_q, macb_q;
	logic [15:0] tagin_q;
	logic        hipin_q, noexp_q;

	logic [N-1:0]  rm_s1;
	logic          dup_s1, full_s1, found_s1;
	logic [IW-1:0] best_s1, free_s1;
	logic          free_ok_s1;

	logic [N-1:0]  hit_c, rm_c, newest_c;
	logic          dup_c, found_c, free_ok_c;
	logic [IW-1:0] best_c, free_c;
	logic [32:0]   sum_c;

	assign sum_c = {1'b0, now_sec} + {16'd0, timeout_sec};

	always_comb begin
		hit_c = '0;
		rm_c = '0;
		newest_c = '0;
		dup_c = 1'b0;
		found_c = 1'b0;
		best_c = '0;
		free_ok_c = 1'b0;
		free_c = '0;
		for (int k = 0; k < N; k++) begin
			if (vld_q[k]) begin
				if (hip_q[k] == hipin_q && ip_q[k] == ipa_q && mac_q[k] == maca_q)
					dup_c = 1'b1;
				if (mode_q == htt_pkg::MODE_M_MAC)
					hit_c[k] = (mac_q[k] != '0) && (mac_q[k] == maca_q || mac_q[k] == macb_q);
				else
					hit_c[k] = hip_q[k] && (ip_q[k] == ipa_q || ip_q[k] == ipb_q);
				if (mode_q == htt_pkg::MODE_DEL_IP)
					rm_c[k] = hip_q[k] && ip_q[k] == ipa_q;
				else if (mode_q == htt_pkg::MODE_SWEEP)
					rm_c[k] = exp_q[k] != '0 && now_q > exp_q[k];
			end else if (!free_ok_c) begin
				free_ok_c = 1'b1;
				free_c = IW'(k);
			end
		end
		for (int k = 0; k < N; k++) begin
			newest_c[k] = hit_c[k];
			for (int j = 0; j < N; j++)
				if (hit_c[j] && rank_q[j] < rank_q[k])
					newest_c[k] = 1'b0;
		end
		found_c = |newest_c;
		for (int k = 0; k < N; k++)
			if (newest_c[k])
				best_c = IW'(k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cnt_q <= '0;
			matched <= 1'b0;
			tag_out <= '0;
			status <= htt_pkg::ST_DONE;
		end else begin
			if (cmd.eval) begin
				rm_s1 <= rm_c;
				dup_s1 <= dup_c;
				full_s1 <= cnt_q >= CW'(N);
				found_s1 <= found_c;
				best_s1 <= best_c;
				free_s1 <= free_c;
				free_ok_s1 <= free_ok_c;
			end
			if (cmd.apply) begin
				matched <= 1'b0;
				tag_out <= '0;
				status <= htt_pkg::ST_DONE;
				case (mode_q)
					htt_pkg::MODE_ADD: begin
						if (dup_s1)
							status <= htt_pkg::ST_DUP;
						else if (full_s1)
							status <= htt_pkg::ST_FULL;
						else if (free_ok_s1) begin
							for (int k = 0; k < N; k++)
								if (vld_q[k])
									rank_q[k] <= rank_q[k] + 1'b1;
							vld_q[free_s1] <= 1'b1;
							ip_q[free_s1] <= ipa_q;
							hip_q[free_s1] <= hipin_q;
							mac_q[free_s1] <= maca_q;
							tag_q[free_s1] <= tagin_q;
							exp_q[free_s1] <= noexp_q ? '0 : newexp_q;
							rank_q[free_s1] <= '0;
							cnt_q <= cnt_q + 1'b1;
						end
					end
					htt_pkg::MODE_DEL_IP, htt_pkg::MODE_SWEEP: begin
						for (int k = 0; k < N; k++) begin
							logic [N-1:0] lower_rm;
							for (int j = 0; j < N; j++)
								lower_rm[j] = rm_s1[j] && rank_q[j] < rank_q[k];
							if (vld_q[k] && !rm_s1[k])
								rank_q[k] <= rank_q[k] - IW'($countones(lower_rm));
						end
						vld_q <= vld_q & ~rm_s1;
						cnt_q <= cnt_q - CW'($countones(rm_s1));
					end
					htt_pkg::MODE_PURGE: begin
						vld_q <= '0;
						cnt_q <= '0;
					end
					htt_pkg::MODE_M_IP, htt_pkg::MODE_M_MAC: begin
						if (found_s1) begin
							matched <= 1'b1;
							tag_out <= tag_q[best_s1];
							if (exp_q[best_s1] != '0)
								exp_q[best_s1] <= newexp_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			now_q <= now_sec;
			ipa_q <= (has_ip || mode != htt_pkg::MODE_ADD) ? ip_a : '0;
			ipb_q <= ip_b;
			maca_q <= (has_mac || mode != htt_pkg::MODE_ADD) ? mac_a : '0;
			macb_q <= mac_b;
			tagin_q <= tag_id;
			hipin_q <= has_ip || mode != htt_pkg::MODE_ADD;
			noexp_q <= no_expiry;
			newexp_q <= sum_c[32] ? 32'hFFFF_FFFF : sum_c[31:0];
		end
	end

	assign active_count = 9'(cnt_q);

endmodule

@@ src/htt_ctrl.sv @@
module htt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output htt_pkg::cmd_t cmd
);

	htt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= htt_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			htt_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = htt_pkg::S_EVAL;
				end
			end
			htt_pkg::S_EVAL: begin
				cmd.eval = 1'b1;
				state_d = htt_pkg::S_APPLY;
			end
			htt_pkg::S_APPLY: begin
				cmd.apply = 1'b1;
				state_d = htt_pkg::S_OUT;
			end
			htt_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall)
					state_d = htt_pkg::S_IDLE;
			end
			default: state_d = htt_pkg::S_IDLE;
		endcase
	end

endmodule

@@ src/host_tag_table_with_aging_top.sv @@
// Host tag table with aging: 32 entries of IP, MAC, tag and expiry, newest first.
// Input channel in_valid/in_stall carries one command word (mode and operands).
// Output channel out_valid/out_stall returns one result word per command:
// matched, tag_out, active_count and status.
// cfg_we/cfg_wdata write the 17-bit timeout; write only while idle.
// Each command passes these steps in order: accept, compare all entries in parallel,
// update the table, present the result. One command is in flight at a time,
// so no new word is accepted until the result of the last one has been taken.
// The compare-then-update sequence over the shared entry registers sets this.
// While the receiver stalls, the result holds and no new word is accepted.
// Reset clears all entries, the count and the timeout to 60 seconds.
module host_tag_table_with_aging_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [31:0] now_sec,
	input  logic [31:0] ip_a,
	input  logic [31:0] ip_b,
	input  logic [47:0] mac_a,
	input  logic [47:0] mac_b,
	input  logic [15:0] tag_id,
	input  logic        has_ip,
	input  logic        has_mac,
	input  logic        no_expiry,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        matched,
	output logic [15:0] tag_out,
	output logic [8:0]  active_count,
	output logic [1:0]  status
);

	htt_pkg::cmd_t cmd;
	logic [16:0]   timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= htt_pkg::TIMEOUT_RST;
		else if (cfg_we)
			timeout_q <= cfg_wdata;
	end

	htt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
	);

	htt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .timeout_sec(timeout_q),
		.mode(mode), .now_sec(now_sec), .ip_a(ip_a), .ip_b(ip_b),
		.mac_a(mac_a), .mac_b(mac_b), .tag_id(tag_id), .has_ip(has_ip),
		.has_mac(has_mac), .no_expiry(no_expiry), .matched(matched),
		.tag_out(tag_out), .active_count(active_count), .status(status)
	);

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		active_count <= 9'(htt_pkg::TABLE_ENTRIES))
		else $error("count overflow");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.eval, cmd.apply}))
		else $error("overlapping commands");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("accept while result pending");
	a_match_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !matched) |-> (tag_out == '0))
		else $error("tag without match");

endmodule

@@ test/htt_checker.sv @@
module htt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [31:0] now_sec,
	input  logic [31:0] ip_a,
	input  logic [31:0] ip_b,
	input  logic [47:0] mac_a,
	input  logic [47:0] mac_b,
	input  logic [15:0] tag_id,
	input  logic        has_ip,
	input  logic        has_mac,
	input  logic        no_expiry,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        matched,
	input  logic [15:0] tag_out,
	input  logic [8:0]  active_count,
	input  logic [1:0]  status,
	output int          err_count,
	output int          pending
);

	typedef struct packed {
		logic        matched;
		logic [15:0] tag;
		logic [8:0]  count;
		logic [1:0]  status;
	} lookup_res_t;

	lookup_res_t expected_q[$];

	logic [16:0] timeout;
	logic        hv   [htt_pkg::TABLE_ENTRIES];
	logic [31:0] hip_v[htt_pkg::TABLE_ENTRIES];
	logic        hhas [htt_pkg::TABLE_ENTRIES];
	logic [47:0] hmac [htt_pkg::TABLE_ENTRIES];
	logic [15:0] htag [htt_pkg::TABLE_ENTRIES];
	logic [31:0] hexp [htt_pkg::TABLE_ENTRIES];
	int          hrank[htt_pkg::TABLE_ENTRIES];
	int          hcount;

	initial err_count = 0;
	assign pending = expected_q.size();

	function automatic logic [31:0] expiry_at(logic [31:0] t);
		logic [32:0] s;
		s = {1'b0, t} + {16'd0, timeout};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic void drop_host(int i);
		int r;
		r = hrank[i];
		hv[i] = 1'b0;
		for (int k = 0; k < htt_pkg::TABLE_ENTRIES; k++)
			if (hv[k] && hrank[k] > r) hrank[k]--;
		if (hcount > 0) hcount--;
	endfunction

	function automatic lookup_res_t apply_command();
		lookup_res_t r;
		logic [31:0] ip;
		logic [47:0] mac;
		logic dup;
		int slot, best;
		logic hit;
		r = '0;
		case (mode)
			htt_pkg::MODE_ADD: begin
				ip = has_ip ? ip_a : 32'd0;
				mac = has_mac ? mac_a : 48'd0;
				dup = 1'b0;
				for (int k = 0; k < htt_pkg::TABLE_ENTRIES; k++)
					if (hv[k] && hhas[k] == has_ip && hip_v[k] == ip && hmac[k] == mac)
						dup = 1'b1;
				if (dup) r.status = htt_pkg::ST_DUP;
				else if (hcount >= htt_pkg::TABLE_ENTRIES) r.status = htt_pkg::ST_FULL;
				else begin
					slot = -1;
					for (int k = 0; k < htt_pkg::TABLE_ENTRIES; k++) begin
						if (hv[k]) hrank[k]++;
						else if (slot < 0) slot = k;
					end
					hv[slot] = 1'b1;
					hip_v[slot] = ip;
					hhas[slot] = has_ip;
					hmac[slot] = mac;
					htag[slot] = tag_id;
					hexp[slot] = no_expiry ? 32'd0 : expiry_at(now_sec);
					hrank[slot] = 0;
					hcount++;
				end
			end
			htt_pkg::MODE_DEL_IP: begin
				for (int k = 0; k < htt_pkg::TABLE_ENTRIES; k++)
					if (hv[k] && hhas[k] && hip_v[k] == ip_a) drop_host(k);
			end
			htt_pkg::MODE_SWEEP: begin
				for (int k = 0; k < htt_pkg::TABLE_ENTRIES; k++)
					if (hv[k] && hexp[k] != 0 && now_sec > hexp[k]) drop_host(k);
			end
			htt_pkg::MODE_PURGE: begin
				for (int k = 0; k < htt_pkg::TABLE_ENTRIES; k++) hv[k] = 1'b0;
				hcount = 0;
			end
			htt_pkg::MODE_M_IP, htt_pkg::MODE_M_MAC: begin
				best = -1;
				for (int k = 0; k < htt_pkg::TABLE_ENTRIES; k++) begin
					if (mode == htt_pkg::MODE_M_MAC)
						hit = hmac[k] != 0 && (hmac[k] == mac_a || hmac[k] == mac_b);
					else
						hit = hhas[k] && (hip_v[k] == ip_a || hip_v[k] == ip_b);
					if (hv[k] && hit && (best < 0 || hrank[k] < hrank[best])) best = k;
				end
				if (best >= 0) begin
					r.matched = 1'b1;
					r.tag = htag[best];
					if (hexp[best] != 0) hexp[best] = expiry_at(now_sec);
				end
			end
			default: ;
		endcase
		r.count = hcount[8:0];
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_res_t e;
		if (!arst_n) begin
			timeout <= htt_pkg::TIMEOUT_RST;
			hcount = 0;
			for (int k = 0; k < htt_pkg::TABLE_ENTRIES; k++) begin
				hv[k] = 1'b0; hip_v[k] = '0; hhas[k] = 1'b0; hmac[k] = '0;
				htag[k] = '0; hexp[k] = '0; hrank[k] = 0;
			end
			expected_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) report("unexpected word", 0, 0);
				else begin
					e = expected_q.pop_front();
					if (matched !== e.matched) report("matched", matched, e.matched);
					if (tag_out !== e.tag) report("tag_out", tag_out, e.tag);
					if (active_count !== e.count) report("active_count", active_count, e.count);
					if (status !== e.status) report("status", status, e.status);
				end
			end
			if (in_valid && !in_stall) expected_q.push_back(apply_command());
			if (cfg_we) timeout <= cfg_wdata;
		end
	end

endmodule

@@ test/tb_top.sv @@
module tb_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [16:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = '0;
	logic [31:0] now_sec = '0, ip_a = '0, ip_b = '0;
	logic [47:0] mac_a = '0, mac_b = '0;
	logic [15:0] tag_id = '0;
	logic        has_ip = 1'b0, has_mac = 1'b0, no_expiry = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        matched;
	logic [15:0] tag_out;
	logic [8:0]  active_count;
	logic [1:0]  status;
	int          err_count, pending;
	bit          calm = 1'b0;
	logic [31:0] clock_sec = 32'd1000;
	logic [31:0] ip_pool[8];
	logic [47:0] mac_pool[8];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	host_tag_table_with_aging_top uut (.*);

	htt_checker chk (.*);

	always @(negedge clk) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= !calm && ($urandom_range(0, 99) < 15);
	end

	task automatic send(logic [2:0] m, logic [31:0] t, logic [31:0] a, logic [31:0] b,
			logic [47:0] ma, logic [47:0] mb, logic [15:0] tg, logic hi, logic hm,
			logic ne);
		while (!calm && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m; now_sec <= t; ip_a <= a; ip_b <= b; mac_a <= ma; mac_b <= mb;
		tag_id <= tg; has_ip <= hi; has_mac <= hm; no_expiry <= ne;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_timeout(logic [16:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic rand_cmd();
		int sel, p;
		logic [2:0] m;
		sel = $urandom_range(0, 99);
		if (sel < 40) m = htt_pkg::MODE_ADD;
		else if (sel < 50) m = htt_pkg::MODE_DEL_IP;
		else if (sel < 58) m = htt_pkg::MODE_SWEEP;
		else if (sel < 60) m = htt_pkg::MODE_PURGE;
		else if (sel < 78) m = htt_pkg::MODE_M_IP;
		else if (sel < 96) m = htt_pkg::MODE_M_MAC;
		else m = 3'($urandom_range(6, 7));
		clock_sec = clock_sec + $urandom_range(0, 40);
		if ($urandom_range(0, 49) == 0) clock_sec = $urandom;
		p = $urandom_range(0, 7);
		send(m, clock_sec,
			($urandom_range(0, 9) < 8) ? ip_pool[p] : $urandom,
			($urandom_range(0, 9) < 6) ? ip_pool[$urandom_range(0, 7)] : $urandom,
			($urandom_range(0, 9) < 8) ? mac_pool[$urandom_range(0, 7)]
				: 48'({$urandom, $urandom}),
			($urandom_range(0, 9) < 6) ? mac_pool[$urandom_range(0, 7)]
				: 48'({$urandom, $urandom}),
			16'($urandom), ($urandom_range(0, 9) < 8), ($urandom_range(0, 9) < 8),
			($urandom_range(0, 9) < 2));
	endtask

	initial begin
		#200000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		for (int i = 0; i < 8; i++) begin
			ip_pool[i] = $urandom;
			mac_pool[i] = 48'({$urandom, $urandom});
		end
		ip_pool[0] = 32'd0;
		ip_pool[1] = 32'hFFFF_FFFF;
		mac_pool[0] = 48'd0;
		mac_pool[1] = 48'hFFFF_FFFF_FFFF;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		calm = 1'b1;
		send(htt_pkg::MODE_M_IP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(htt_pkg::MODE_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0, 48'hFFFF_FFFF_FFFF, 0,
			16'hFFFF, 1, 1, 0);
		send(htt_pkg::MODE_ADD, 5, 32'hFFFF_FFFF, 0, 48'hFFFF_FFFF_FFFF, 0, 16'h1, 1, 1, 0);
		send(htt_pkg::MODE_ADD, 5, 32'h0A00_0001, 0, 0, 0, 16'h22, 1, 0, 1);
		send(htt_pkg::MODE_ADD, 5, 32'h1234, 0, 48'h0000_0000_0abc, 0, 16'h33, 0, 1, 0);
		send(htt_pkg::MODE_M_IP, 10, 32'h0A00_0001, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
		send(htt_pkg::MODE_M_IP, 10, 0, 0, 0, 0, 0, 0, 0, 0);
		send(htt_pkg::MODE_M_MAC, 10, 0, 0, 0, 48'h0abc, 0, 0, 0, 0);
		send(htt_pkg::MODE_M_MAC, 10, 0, 0, 0, 0, 0, 0, 0, 0);
		send(htt_pkg::MODE_SWEEP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
		send(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(htt_pkg::MODE_DEL_IP, 0, 32'h0A00_0001, 0, 0, 0, 0, 0, 0, 0);
		set_timeout(17'd0);
		send(htt_pkg::MODE_ADD, 0, 32'h77, 0, 48'h77, 0, 16'h77, 1, 1, 0);
		send(htt_pkg::MODE_SWEEP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
		set_timeout(17'h1FFFF);
		for (int i = 0; i < 34; i++)
			send(htt_pkg::MODE_ADD, 32'hFFFF_0000, 32'h100 + i, 0, 48'h500 + i, 0,
				16'(i), 1, 1, 0);
		send(htt_pkg::MODE_SWEEP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
		send(htt_pkg::MODE_PURGE, 0, 0, 0, 0, 0, 0, 0, 0, 0);

		calm = 1'b0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_timeout(17'd60);
				1: set_timeout(17'd86400);
				2: set_timeout(17'd0);
				3: set_timeout(17'($urandom_range(1, 300)));
				4: set_timeout(17'd30);
				default: set_timeout(17'($urandom));
			endcase
			calm = (ph == 4);
			for (int i = 0; i < 225; i++) rand_cmd();
			calm = 1'b0;
			drain();
		end
		drain();
		if (err_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
src/htt_pkg.sv
src/htt_datapath.sv
src/htt_ctrl.sv
src/host_tag_table_with_aging_top.sv
test/htt_checker.sv
test/tb_top.sv
